@@ hdl/ise_pkg.sv @@
// Shared types and constants of the insertion sort engine.
package ise_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast value, shifting larger entries up
    logic shift;   // move every entry one place toward the output end
  } cell_ctrl_t;

endpackage

@@ hdl/ise_cell.sv @@
// One cell of the sorting chain: a stored value, its occupied bit and the compare.
module ise_cell
  import ise_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  data_t      ins_value,
  input  data_t      left_value,
  input  logic       left_occ,
  input  logic       left_gt,
  input  data_t      right_value,
  input  logic       right_occ,
  output data_t      value,
  output logic       occ,
  output logic       gt
);

  // An empty cell acts as plus infinity, so the first empty cell takes the value.
  assign gt = !occ || (value > ins_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (gt) begin
        value <= left_gt ? left_value : ins_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.insert) begin
      occ <= occ | left_occ;
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end
  end

endmodule

@@ hdl/insertion_sort_engine_core.sv @@
// Top level of the insertion sort engine: a systolic chain of compare-and-shift cells.
//
// The engine accepts signed 32-bit values one per cycle and keeps them in a
// chain of MAX_ITEMS cells that is always sorted in ascending order. Every
// accepted value is broadcast to all cells; each cell holding a strictly
// greater value (or empty) moves its neighbor's entry up one place, so equal
// values keep their arrival order and the sort is stable. A list streams in at
// one element per cycle. Values that arrive while all cells are occupied are
// dropped, and every result of that list then carries overflow. The transfer
// of an element with last_in set ends the list: the chain then shifts its
// contents toward cell 0, which drives the output port directly, giving one
// result per cycle while out_ready is high. During this drain in_ready is low,
// so no new element is taken while the stored list is emitted. The final
// result carries last_out; after its transfer the chain is empty and in_ready
// returns high.
module insertion_sort_engine_core
  import ise_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  data_t value_in,
  input  logic  last_in,
  output logic  out_valid,
  input  logic  out_ready,
  output data_t value_out,
  output logic  last_out,
  output logic  overflow
);

  data_t                cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] cell_occ;
  logic [MAX_ITEMS-1:0] cell_gt;
  cell_ctrl_t           ctrl;

  logic draining;   // the stored list is being emitted
  logic dropped;    // an element of the current list was dropped

  logic in_fire;
  logic out_fire;
  logic full;

  assign full     = cell_occ[MAX_ITEMS-1];
  assign in_ready = !draining;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Inserts only happen outside the drain and shifts only inside it.
  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;

  // Cell 0 always sees an occupied, not-greater neighbor on its left, and the
  // top cell sees an empty neighbor on its right.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    data_t left_value;
    logic  left_occ;
    logic  left_gt;
    data_t right_value;
    logic  right_occ;

    if (i == 0) begin : g_first
      assign left_value = value_in;
      assign left_occ   = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
      assign left_occ   = cell_occ[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign right_value = cell_value[i];
      assign right_occ   = 1'b0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
      assign right_occ   = cell_occ[i+1];
    end

    ise_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .ins_value   (value_in),
      .left_value  (left_value),
      .left_occ    (left_occ),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_occ   (right_occ),
      .value       (cell_value[i]),
      .occ         (cell_occ[i]),
      .gt          (cell_gt[i])
    );
  end

  // The drain starts with the transfer of the last element and ends with the
  // transfer of the result that carries last_out.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (in_fire && last_in) begin
      draining <= 1'b1;
    end else if (out_fire && last_out) begin
      draining <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (in_fire && full) begin
      dropped <= 1'b1;
    end else if (out_fire && last_out) begin
      dropped <= 1'b0;
    end
  end

  // Cell 0 is the output register; the result is the final one when cell 1 is empty.
  assign out_valid = draining;
  assign value_out = cell_value[0];
  assign last_out  = !cell_occ[1];
  assign overflow  = dropped;

  // Occupied cells always form a contiguous run starting at cell 0.
  a_occ_contiguous: assert property (@(posedge clk) disable iff (rst)
    ((cell_occ + MAX_ITEMS'(1)) & cell_occ) == '0)
    else $error("occupied cells are not contiguous from cell 0");

  // While results are offered, the output cell holds a stored element.
  a_out_occupied: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cell_occ[0])
    else $error("result offered from an empty output cell");

  // A value taken while the chain is full marks the list as overflowed.
  a_drop_flags: assert property (@(posedge clk) disable iff (rst)
    (in_fire && full) |=> dropped)
    else $error("dropped element did not set the overflow flag");

  // After the final result the chain is empty and ready for a new list.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_out) |=> (!draining && (cell_occ == '0) && !dropped))
    else $error("chain not cleared after the final result");

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench of the insertion sort engine, fed with directed and random lists.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ise_pkg::*;

  // Capacity of the engine under test; the shadow sorter below uses the same depth.
  localparam int SORT_DEPTH = 16;
  // Least number of random elements queued after the directed lists, in whole lists.
  localparam int RANDOM_ITEMS = 410;
  // Longest idle stretch that either side inserts between two transfers.
  localparam int GAP_MAX = 10;
  // Quiet cycles after the last expected result, to catch stray results.
  localparam int TAIL_CYCLES = 40;
  localparam int DIR_ROWS = 10;

  localparam data_t VAL_MIN = data_t'(32'h8000_0000);
  localparam data_t VAL_MAX = data_t'(32'h7FFF_FFFF);
  localparam data_t FILL_PATTERN = data_t'(32'h5A5A_5A5A);

  // One list element as it goes to the engine. Where n_typed is nonzero the list that
  // this element closes has a hand-written outcome: n_typed results, all carrying
  // typed_value and typed_ovf, the final one flagged as last.
  typedef struct {
    data_t value;
    logic  last;
    int    n_typed;
    data_t typed_value;
    logic  typed_ovf;
  } element_t;

  // One sorted result as the engine should emit it.
  typedef struct {
    data_t value;
    logic  last;
    logic  ovf;
  } sorted_res_t;

  // A row of the directed table: an element and how many times it is repeated.
  typedef struct {
    element_t elem;
    int       reps;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  in_valid;
  logic  in_ready;
  data_t value_in;
  logic  last_in;
  logic  out_valid;
  logic  out_ready;
  data_t value_out;
  logic  last_out;
  logic  overflow;

  // Elements waiting to be transferred into the engine, oldest first.
  element_t    feed_q[$];
  // Sorted results that the engine still owes, oldest first.
  sorted_res_t sorted_due_q[$];
  dir_row_t    dir_table[DIR_ROWS];

  // Shadow copy of the engine's state, kept by the sorting predictor.
  data_t shadow_store[SORT_DEPTH];
  int    shadow_fill = 0;
  logic  shadow_dropped = 1'b0;

  int   mismatches = 0;
  int   items_fed = 0;
  int   results_seen = 0;
  int   lists_closed = 0;
  int   overflow_lists = 0;
  int   feed_gap = 0;
  int   drain_wait = 0;
  logic feed_calm = 1'b0;
  logic drain_calm = 1'b0;
  logic feed_fire;
  logic feed_next;

  insertion_sort_engine_core #(
    .MAX_ITEMS(SORT_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value_in (value_in),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value_out(value_out),
    .last_out (last_out),
    .overflow (overflow)
  );

  always #2 clk = ~clk;

  // Every mismatch goes through here: one line each, and a count for the summary.
  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Sorting predictor. The element is inserted behind every stored entry that is not
  // greater, which keeps equal values in arrival order, or it is dropped when the
  // store is full. A last element closes the list: the whole store is queued in ascending
  // order as expected results (its hand-written outcome instead, if any), then emptied.
  task automatic insert_and_drain(element_t e);
    int          pos;
    int          k;
    sorted_res_t r;
    if (shadow_fill < SORT_DEPTH) begin
      pos = shadow_fill;
      while (pos > 0 && shadow_store[pos-1] > e.value) begin
        shadow_store[pos] = shadow_store[pos-1];
        pos--;
      end
      shadow_store[pos] = e.value;
      shadow_fill++;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (e.last) begin
      if (e.n_typed != 0) begin
        for (k = 0; k < e.n_typed; k++) begin
          r.value = e.typed_value;
          r.last  = (k == e.n_typed - 1);
          r.ovf   = e.typed_ovf;
          sorted_due_q.push_back(r);
        end
      end else begin
        for (k = 0; k < shadow_fill; k++) begin
          r.value = shadow_store[k];
          r.last  = (k == shadow_fill - 1);
          r.ovf   = shadow_dropped;
          sorted_due_q.push_back(r);
        end
      end
      lists_closed++;
      if (shadow_dropped) begin
        overflow_lists++;
      end
      shadow_fill    = 0;
      shadow_dropped = 1'b0;
    end
  endtask

  // Compares the result of the current output transfer with the oldest one owed.
  task automatic check_result();
    sorted_res_t want;
    if (sorted_due_q.size() == 0) begin
      report_mismatch($sformatf("result with none owed: value=%0d last=%0b ovf=%0b",
                                value_out, last_out, overflow));
    end else begin
      want = sorted_due_q.pop_front();
      if (value_out !== want.value) begin
        report_mismatch($sformatf("value_out %0d, wanted %0d", value_out, want.value));
      end
      if (last_out !== want.last) begin
        report_mismatch($sformatf("last_out %0b, wanted %0b (value %0d)",
                                  last_out, want.last, want.value));
      end
      if (overflow !== want.ovf) begin
        report_mismatch($sformatf("overflow %0b, wanted %0b (value %0d)",
                                  overflow, want.ovf, want.value));
      end
    end
  endtask

  function automatic dir_row_t dir_row(data_t v, logic l, int reps, int n_typed,
                                       data_t tv, logic tovf);
    dir_row_t r;
    r.elem.value       = v;
    r.elem.last        = l;
    r.elem.n_typed     = n_typed;
    r.elem.typed_value = tv;
    r.elem.typed_ovf   = tovf;
    r.reps             = reps;
    return r;
  endfunction

  // A calm side never idles; otherwise its idle gap is drawn at random, bounded by GAP_MAX.
  function automatic int draw_gap(logic calm);
    if (calm) begin
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  // Mostly short and medium lists, with exactly full lists, singletons and lists that
  // run past the capacity mixed in.
  function automatic int draw_list_len();
    case ($urandom_range(0, 9))
      0: return $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 6);
      1: return SORT_DEPTH;
      2: return 1;
      default: return $urandom_range(2, SORT_DEPTH - 1);
    endcase
  endfunction

  // Style 0 gives many duplicates near zero, style 1 the corners of the signed range,
  // anything else the full 32-bit space.
  function automatic data_t draw_value(int style);
    data_t v;
    case (style)
      0: v = data_t'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MAX;
          2: v = '0;
          3: v = -1;
          4: v = VAL_MIN + 1;
          default: v = VAL_MAX - 1;
        endcase
      end
      default: v = data_t'($urandom);
    endcase
    return v;
  endfunction

  // Input side. The transfer of an element runs it through the predictor. After each
  // transfer a fresh gap is drawn; with a gap of zero the next element follows in the
  // very next cycle and in_valid simply stays high. While in_valid is high and the
  // engine holds in_ready low (during a drain), the payload is left untouched.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      feed_fire = in_valid && in_ready;
      if (feed_fire) begin
        insert_and_drain(feed_q.pop_front());
        items_fed++;
        if (items_fed % 40 == 0) begin
          feed_calm = ($urandom_range(0, 3) == 0);
        end
        feed_gap = draw_gap(feed_calm);
      end
      if (in_valid && !feed_fire) begin
        feed_next = 1'b1;
      end else if (feed_gap != 0) begin
        feed_gap--;
        feed_next = 1'b0;
      end else if (feed_q.size() != 0) begin
        feed_next = 1'b1;
        value_in <= feed_q[0].value;
        last_in  <= feed_q[0].last;
      end else begin
        feed_next = 1'b0;
      end
      in_valid <= feed_next;
    end
  end

  // Output side. Each result transfer is checked, then out_ready drops for a freshly
  // drawn gap unless that gap is zero. The ready is raised without waiting for out_valid.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result();
        results_seen++;
        if (results_seen % 40 == 0) begin
          drain_calm = ($urandom_range(0, 3) == 0);
        end
        drain_wait = draw_gap(drain_calm);
      end
      if (drain_wait != 0) begin
        drain_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int       r;
    int       k;
    int       n;
    int       style;
    int       random_fed;
    element_t e;

    rst       = 1'b1;
    in_valid  = 1'b0;
    value_in  = '0;
    last_in   = 1'b0;
    out_ready = 1'b0;

    // Directed lists. Singletons at the extremes have an obvious outcome, as has a
    // full store of one repeated value closed by an element that must be dropped.
    // The short mixed list in between is left to the predictor.
    //                       value         last  reps n_typed typed_value   typed_ovf
    dir_table[0] = dir_row(VAL_MIN,      1'b1, 1,   1,         VAL_MIN,      1'b0);
    dir_table[1] = dir_row(VAL_MAX,      1'b1, 1,   1,         VAL_MAX,      1'b0);
    dir_table[2] = dir_row('0,           1'b1, 1,   1,         '0,           1'b0);
    dir_table[3] = dir_row(-1,           1'b1, 1,   1,         -1,           1'b0);
    dir_table[4] = dir_row(7,            1'b0, 1,   0,         '0,           1'b0);
    dir_table[5] = dir_row(VAL_MAX,      1'b0, 1,   0,         '0,           1'b0);
    dir_table[6] = dir_row(VAL_MIN,      1'b0, 1,   0,         '0,           1'b0);
    dir_table[7] = dir_row(7,            1'b1, 1,   0,         '0,           1'b0);
    dir_table[8] = dir_row(FILL_PATTERN, 1'b0, SORT_DEPTH, 0,  '0,           1'b0);
    dir_table[9] = dir_row(VAL_MIN,      1'b1, 1,   SORT_DEPTH, FILL_PATTERN, 1'b1);

    for (r = 0; r < DIR_ROWS; r++) begin
      for (k = 0; k < dir_table[r].reps; k++) begin
        feed_q.push_back(dir_table[r].elem);
      end
    end

    // Random lists, each closed by an element marked last; one value style per list.
    random_fed = 0;
    while (random_fed < RANDOM_ITEMS) begin
      n     = draw_list_len();
      style = $urandom_range(0, 3);
      for (k = 0; k < n; k++) begin
        e.value       = draw_value(style);
        e.last        = (k == n - 1);
        e.n_typed     = 0;
        e.typed_value = '0;
        e.typed_ovf   = 1'b0;
        feed_q.push_back(e);
      end
      random_fed += n;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for every element to be taken, then for every owed result, then a quiet tail.
    while (feed_q.size() != 0) @(posedge clk);
    while (sorted_due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d lists (%0d of them over capacity) from %0d elements,",
             lists_closed, overflow_lists, items_fed);
    $display("with %0d sorted results checked and %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog. The bound lies beyond the slowest correct run, with every gap and stall at
  // its longest, so only a hung run reaches it.
  initial begin
    #400_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
